// ===== src/road_record_parser_defines.svh =====
// assertion macros for the road record parser
`ifndef ROAD_RECORD_PARSER_DEFINES_SVH
`define ROAD_RECORD_PARSER_DEFINES_SVH
// assert that a implies b at every clock edge out of reset
`define RRP_ASSERT_IMPL(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("rrp check failed");
// assert that a implies b in the following cycle
`define RRP_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("rrp check failed");
`endif

// ===== src/rrp_pkg.sv =====
// types and constants of the road record parser
package rrp_pkg;
	typedef enum logic [3:0] {
		K_LABEL = 4'd0, K_SEGMENT = 4'd1, K_FLAGS = 4'd2, K_LENGTH = 4'd3,
		K_LEVEL_COUNT = 4'd4, K_LEVEL_ITEM = 4'd5, K_HOUSE = 4'd6, K_ADDR_FLAGS = 4'd7,
		K_NUM_SIZE = 4'd8, K_NUM_BYTE = 4'd9, K_ZIP = 4'd10, K_CITY = 4'd11,
		K_REGION = 4'd12, K_NODE_PTR = 4'd13, K_ERROR = 4'd14
	} kind_t;

	typedef enum logic [12:0] {
		PH_IDLE      = 13'h0001, PH_WORD      = 13'h0002, PH_FLAGS     = 13'h0004,
		PH_LENGTH    = 13'h0008, PH_LEVELS    = 13'h0010, PH_ITEMS     = 13'h0020,
		PH_HOUSE     = 13'h0040, PH_ADDRFLAGS = 13'h0080, PH_NUMSIZE   = 13'h0100,
		PH_NUMBYTES  = 13'h0200, PH_INDEX     = 13'h0400, PH_NODEHDR   = 13'h0800,
		PH_NODEPTR   = 13'h1000
	} phase_t;

	localparam logic [1:0] REG_ZIP = 2'd0;
	localparam logic [1:0] REG_CITY = 2'd1;
	localparam logic [1:0] REG_REGION = 2'd2;
	localparam logic [27:0] ERR_LABELS = 28'd0;
	localparam logic [27:0] ERR_SEGMENTS = 28'd1;

	typedef struct packed {
		logic [3:0]  result_kind;
		logic [27:0] result_value;
		logic [1:0]  address_slot;
		logic        record_last;
	} result_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       begin_record;
	} in_word_t;
endpackage

// ===== src/rrp_stream_if.sv =====
// valid/ready channel carrying one payload word
interface rrp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/rrp_core.sv =====
// per-byte state update of the record parser
module rrp_core import rrp_pkg::*; #(
	parameter int MAX_LABELS = 4,
	parameter int MAX_SEGMENTS = 100,
	parameter int MAX_LEVELS = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_word_t   in_word,
	input  logic [1:0] zip_bytes,
	input  logic [1:0] city_bytes,
	input  logic [1:0] region_bytes,
	output logic       have,
	output result_t    res
);
	phase_t      phase_q, ph;
	logic [1:0]  bpos_q, bpos;
	logic [23:0] acc_q, acc;
	logic        seg_q, seg;
	logic [3:0]  lab_q, lab;
	logic [7:0]  segc_q, segc;
	logic [4:0]  lvl_q, lvl;
	logic [10:0] items_q, items;
	logic [7:0]  rflags_q, rflags;
	logic [7:0]  aflags_q, aflags;
	logic [1:0]  slot_q, slot;
	logic [7:0]  str_q, str;
	logic [1:0]  plen_q, plen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; bpos_q <= '0; acc_q <= '0; seg_q <= 1'b0;
			lab_q <= '0; segc_q <= '0; lvl_q <= '0; items_q <= '0;
			rflags_q <= '0; aflags_q <= '0; slot_q <= '0; str_q <= '0; plen_q <= '0;
		end else if (step) begin
			phase_q <= ph; bpos_q <= bpos; acc_q <= acc; seg_q <= seg;
			lab_q <= lab; segc_q <= segc; lvl_q <= lvl; items_q <= items;
			rflags_q <= rflags; aflags_q <= aflags; slot_q <= slot; str_q <= str;
			plen_q <= plen;
		end
	end

	logic [7:0]  b;
	logic [23:0] wacc;
	logic        done3;
	logic [1:0]  nxt_slot;
	logic        slot_found;
	logic [1:0]  ftype;
	logic        flag_tail;
	logic [1:0]  idx_reg;
	logic [10:0] items_sum;
	logic [1:0]  plen_new;

	// first slot at or after 'from' that takes bytes
	function automatic logic [2:0] find_slot(input logic [7:0] af, input logic [2:0] from);
		logic [2:0] r;
		r = 3'd3;
		for (int s = 2; s >= 0; s--) begin
			if (s >= from && (af[2+2*s +: 2] == 2'd0 || af[2+2*s +: 2] == 2'd2))
				r = 3'(s);
		end
		return r;
	endfunction

	always_comb begin
		logic [2:0] fs;
		logic [2:0] from;
		b = in_word.data_byte;
		ph = phase_q; bpos = bpos_q; acc = acc_q; seg = seg_q; lab = lab_q;
		segc = segc_q; lvl = lvl_q; items = items_q; rflags = rflags_q;
		aflags = aflags_q; slot = slot_q; str = str_q; plen = plen_q;
		if (in_word.begin_record) begin
			ph = PH_WORD; bpos = '0; acc = '0; seg = 1'b0; lab = '0; segc = '0;
			lvl = '0; items = '0; rflags = '0; aflags = '0; slot = '0; str = '0;
			plen = '0;
		end
		have = 1'b0;
		res = '0;
		wacc = acc;
		case (bpos)
			2'd0: wacc[7:0] = wacc[7:0] | b;
			2'd1: wacc[15:8] = wacc[15:8] | b;
			2'd2: wacc[23:16] = wacc[23:16] | b;
			default: wacc = acc;
		endcase
		done3 = (bpos == 2'd2);
		flag_tail = rflags[6];
		idx_reg = (slot == 2'd0) ? zip_bytes : ((slot == 2'd1) ? city_bytes : region_bytes);
		items_sum = items + 11'(b[5:0]);
		plen_new = (b[1:0] == 2'd1) ? 2'd2 : ((b[1:0] == 2'd2) ? 2'd3 :
			((b[1:0] == 2'd3) ? 2'd1 : 2'd0));
		ftype = '0;
		nxt_slot = '0;
		slot_found = 1'b0;
		from = 3'd0;
		case (ph)
			PH_NUMSIZE, PH_NUMBYTES, PH_INDEX: from = {1'b0, slot} + 3'd1;
			default: from = 3'd0;
		endcase
		fs = find_slot((ph == PH_ADDRFLAGS) ? b : aflags, from);
		slot_found = (fs != 3'd3);
		nxt_slot = fs[1:0];
		ftype = 2'(((ph == PH_ADDRFLAGS) ? b : aflags) >> (2 + 2 * nxt_slot));
		res.address_slot = '0;
		case (ph)
			PH_WORD: begin
				if (done3) begin
					bpos = '0; acc = '0;
					if (seg) begin
						if (segc < 8'(MAX_SEGMENTS)) begin
							segc = segc + 8'd1;
							have = 1'b1; res.result_kind = K_SEGMENT;
							res.result_value = 28'(wacc[22:0]);
						end else begin
							ph = PH_IDLE; have = 1'b1; res.result_kind = K_ERROR;
							res.result_value = ERR_SEGMENTS;
						end
					end else begin
						if (wacc[22]) seg = 1'b1;
						if (wacc[21:0] != '0) begin
							lab = lab + 4'd1;
							have = 1'b1;
							if (lab >= 4'(MAX_LABELS)) begin
								ph = PH_IDLE; res.result_kind = K_ERROR;
								res.result_value = ERR_LABELS;
							end else begin
								res.result_kind = K_LABEL;
								res.result_value = 28'(wacc[21:0]);
							end
						end
					end
					if (ph != PH_IDLE && wacc[23]) ph = PH_FLAGS;
				end else begin
					bpos = bpos + 2'd1; acc = wacc;
				end
			end
			PH_FLAGS: begin
				rflags = b; ph = PH_LENGTH; have = 1'b1;
				res.result_kind = K_FLAGS; res.result_value = 28'(b);
			end
			PH_LENGTH: begin
				if (done3) begin
					bpos = '0; acc = '0; ph = PH_LEVELS; have = 1'b1;
					res.result_kind = K_LENGTH;
					res.result_value = {1'b0, wacc, 3'b000} + {3'b000, wacc, 1'b0};
				end else begin
					bpos = bpos + 2'd1; acc = wacc;
				end
			end
			PH_LEVELS: begin
				items = items_sum; lvl = lvl + 5'd1; have = 1'b1;
				res.result_kind = K_LEVEL_COUNT; res.result_value = 28'(b[5:0]);
				if (b[7] || lvl >= 5'(MAX_LEVELS)) begin
					bpos = '0; acc = '0;
					if (items_sum != '0) ph = PH_ITEMS;
					else if (rflags[4]) ph = PH_HOUSE;
					else ph = flag_tail ? PH_NODEHDR : PH_IDLE;
				end
			end
			PH_ITEMS: begin
				if (done3) begin
					bpos = '0; acc = '0; have = 1'b1;
					res.result_kind = K_LEVEL_ITEM; res.result_value = 28'(wacc);
					if (items != '0) items = items - 11'd1;
					if (items == '0) begin
						if (rflags[4]) ph = PH_HOUSE;
						else ph = flag_tail ? PH_NODEHDR : PH_IDLE;
					end
				end else begin
					bpos = bpos + 2'd1; acc = wacc;
				end
			end
			PH_HOUSE: begin
				ph = PH_ADDRFLAGS; have = 1'b1;
				res.result_kind = K_HOUSE; res.result_value = 28'(b);
			end
			PH_ADDRFLAGS: begin
				aflags = b; have = 1'b1;
				res.result_kind = K_ADDR_FLAGS; res.result_value = 28'(b);
			end
			PH_NUMSIZE: begin
				have = 1'b1; res.result_kind = K_NUM_SIZE; res.result_value = 28'(b);
				res.address_slot = slot;
				if (b != 8'd0) begin
					str = b; ph = PH_NUMBYTES;
				end
			end
			PH_NUMBYTES: begin
				have = 1'b1; res.result_kind = K_NUM_BYTE; res.result_value = 28'(b);
				res.address_slot = slot;
				if (str != '0) str = str - 8'd1;
			end
			PH_INDEX: begin
				if (bpos == 2'd1 || !idx_reg[1]) begin
					bpos = '0; acc = '0; have = 1'b1;
					res.result_kind = K_ZIP + 4'(slot);
					res.result_value = 28'(wacc[15:0]);
					res.address_slot = slot;
				end else begin
					bpos = bpos + 2'd1; acc = wacc;
				end
			end
			PH_NODEHDR: begin
				plen = plen_new; bpos = '0; acc = '0;
				if (plen_new == '0) begin
					ph = PH_IDLE; have = 1'b1; res.result_kind = K_NODE_PTR;
					res.result_value = '0;
				end else ph = PH_NODEPTR;
			end
			PH_NODEPTR: begin
				if (bpos + 2'd1 >= plen) begin
					bpos = '0; acc = '0; ph = PH_IDLE; have = 1'b1;
					res.result_kind = K_NODE_PTR; res.result_value = 28'(wacc);
				end else begin
					bpos = bpos + 2'd1; acc = wacc;
				end
			end
			default: ph = PH_IDLE;
		endcase
		// advance to the next address slot that takes bytes
		if ((ph == PH_ADDRFLAGS && have && res.result_kind == K_ADDR_FLAGS) ||
			(ph == PH_NUMSIZE && phase_q != PH_IDLE && b == 8'd0 && have &&
				res.result_kind == K_NUM_SIZE) ||
			(ph == PH_NUMBYTES && have && res.result_kind == K_NUM_BYTE && str == '0) ||
			(ph == PH_INDEX && have)) begin
			if (slot_found) begin
				slot = nxt_slot; bpos = '0; acc = '0;
				ph = (ftype == 2'd0) ? PH_NUMSIZE : PH_INDEX;
			end else ph = flag_tail ? PH_NODEHDR : PH_IDLE;
		end
		res.record_last = (ph == PH_IDLE);
	end
endmodule

// ===== src/road_record_parser.sv =====
// top level of the road record parser
// road_record_parser: byte-serial parser for one road record.
// in: sink channel of words {data_byte, begin_record}; a word with
//   begin_record set starts a new record and drops any record in progress.
//   words outside a record are ignored.
// out: source channel of result words {result_kind, result_value,
//   address_slot, record_last}; record_last marks the last result of a record
//   or an error.
// cfg: write port; index 0 zip, 1 city, 2 region bytes per index
//   (0 or 1 mean one byte, 2 or 3 two bytes). write only while idle.
// throughput: one word per cycle when not stalled; the parse state is
//   updated by short combinational logic from the accepted word.
// result: a result sits in the output register in the cycle after the word
//   that completes its field is accepted.
// stall: the output register holds its word; a new input word is accepted
//   while the output is empty or being taken in the same cycle, so with a
//   ready receiver the stream runs at full rate.
// reset: arst_n clears the parse state to idle, empties the output register
//   and sets all three index widths to one byte.
`include "road_record_parser_defines.svh"
module road_record_parser import rrp_pkg::*; #(
	parameter int MAX_LABELS = 4,
	parameter int MAX_SEGMENTS = 100,
	parameter int MAX_LEVELS = 25
) (
	input logic       clk,
	input logic       arst_n,
	rrp_stream_if.sink   in_ch,
	rrp_stream_if.source out_ch,
	input logic       cfg_we,
	input logic [1:0] cfg_index,
	input logic [1:0] cfg_data
);
	// index width registers
	logic [1:0] zip_q, city_q, region_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zip_q <= 2'd1; city_q <= 2'd1; region_q <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZIP: zip_q <= cfg_data;
				REG_CITY: city_q <= cfg_data;
				REG_REGION: region_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register
	logic    out_valid_q;
	result_t out_q;
	logic    step, have;
	result_t res;

	// take a word when the output slot is free or drains this cycle
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign step = in_ch.valid && in_ch.ready;

	rrp_core #(
		.MAX_LABELS(MAX_LABELS), .MAX_SEGMENTS(MAX_SEGMENTS), .MAX_LEVELS(MAX_LEVELS)
	) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .in_word(in_ch.payload),
		.zip_bytes(zip_q), .city_bytes(city_q), .region_bytes(region_q),
		.have(have), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (in_ch.ready) out_valid_q <= step && have;
	end
	always_ff @(posedge clk) begin
		if (step && have) out_q <= res;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	// a held result may not be overwritten
	`RRP_ASSERT_IMPL(a_no_overrun, out_valid_q && !out_ch.ready, !in_ch.ready)
	// a stalled result stays valid
	`RRP_ASSERT_NEXT(a_hold, out_valid_q && !out_ch.ready, out_valid_q)
	// a result in the register has a defined kind
	`RRP_ASSERT_IMPL(a_kind, out_valid_q, out_q.result_kind <= K_ERROR)
endmodule
